### rtl/auto_ranging_axis_normalizer_core_assert.svh
// Assertion macros shared by the normalizer checker.
`ifndef AUTO_RANGING_AXIS_NORMALIZER_CORE_ASSERT_SVH
`define AUTO_RANGING_AXIS_NORMALIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ARN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/arn_pkg.sv
// Shared types and constants for the auto-ranging axis normalizer.
package arn_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int NUM_AXES_DEF    = 4;

  localparam int ACT_BITS    = 2;
  localparam int AXIS_BITS   = 2;
  localparam int ACTIVE_BITS = 4;
  localparam int POS_BITS    = 16;

  localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 4'hF;

  // 100*d/r with d <= r never exceeds 100, so seven quotient bits suffice
  localparam int QUO_BITS     = 7;
  localparam int SCALE_FACTOR = 100;
  localparam logic [QUO_BITS-1:0] POS_MAX = 7'd99;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_SCALE    = 2'd0,
    ACT_RESET    = 2'd1,
    ACT_SET_LOW  = 2'd2,
    ACT_SET_HIGH = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### rtl/arn_if.sv
// Channel interfaces: sample input, result output, configuration write.
interface arn_in_if import arn_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [ACT_BITS-1:0]    action;
  logic [AXIS_BITS-1:0]   axis;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, action, axis, sample, input ready);
  modport sink   (input valid, action, axis, sample, output ready);
endinterface

interface arn_out_if import arn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] position;
  logic                scaled;

  modport source (output valid, position, scaled, input ready);
  modport sink   (input valid, position, scaled, output ready);
endinterface

interface arn_cfg_if import arn_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ACTIVE_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/auto_ranging_axis_normalizer_core.sv
// Top level of the auto-ranging axis normalizer (per-axis min/max bounds, 0..99 scaling).
// A scale transfer with a non-empty range passes through bound update, setup, 7 restoring-divide
// steps and result load; all others skip the divide. One item is in flight at a time, and a
// new sample is taken only once the previous result has moved into the output register.
// Output register decouples the sides: the next sample is taken while a result waits.
// Reset (rst_n low, synchronous): all bounds zero, active_axes all ones, output empty.
module auto_ranging_axis_normalizer_core import arn_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int NUM_AXES    = NUM_AXES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  arn_in_if.sink    in_ch,
  arn_out_if.source out_ch,
  arn_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int MUL_W = SAMPLE_BITS + QUO_BITS;
  localparam int CNT_W = $clog2(QUO_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_BITS - 1);

  // control
  state_t                 state_r, state_nxt;
  logic [ACTIVE_BITS-1:0] active_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   out_valid_r;
  logic                   in_rdy;
  logic                   out_load;

  // calibration bounds, one pair per axis
  logic [SAMPLE_BITS-1:0] low_r  [NUM_AXES];
  logic [SAMPLE_BITS-1:0] high_r [NUM_AXES];

  // captured item
  act_t                   act_r;
  logic [AXIS_BITS-1:0]   axis_r;
  logic [SAMPLE_BITS-1:0] samp_r;

  // divider: rem_r is the partial remainder, quo_r shifts dividend bits out
  // at the top and quotient bits in at the bottom
  logic [SAMPLE_BITS-1:0] rem_r;
  logic [QUO_BITS-1:0]    quo_r;
  logic [SAMPLE_BITS-1:0] rng_r;

  // result waiting for the output register, and the output register itself
  logic [POS_BITS-1:0]    res_pos_r;
  logic                   res_scaled_r;
  logic [POS_BITS-1:0]    out_pos_r;
  logic                   out_scaled_r;

  logic                   in_xfer;
  logic                   axis_ok;
  logic                   axis_on;
  logic [IDX_W-1:0]       idx;
  logic [SAMPLE_BITS-1:0] lo_cur;
  logic [SAMPLE_BITS-1:0] hi_cur;
  logic                   go_div;
  logic                   wr_lo;
  logic                   wr_hi;
  logic [SAMPLE_BITS-1:0] diff;
  logic [MUL_W-1:0]       prod;
  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS:0]   trial_sub;
  logic                   fits;
  logic [QUO_BITS-1:0]    quo_step;
  logic [QUO_BITS-1:0]    quo_clamp;

  assign in_xfer = in_ch.valid && in_rdy;

  // Axis decode. Axes at or above NUM_AXES are never written and never scaled.
  assign axis_ok = int'(axis_r) < NUM_AXES;
  assign axis_on = axis_ok && active_r[axis_r];
  assign idx     = IDX_W'(axis_r);
  assign lo_cur  = low_r[idx];
  assign hi_cur  = high_r[idx];

  // Divide only for an active scale with a non-empty range (bounds already updated).
  assign go_div = (act_r == ACT_SCALE) && axis_on && (lo_cur != hi_cur);

  // After the bound update the sample never sits below low, so diff is the
  // plain offset; with inverted bounds it is zero and the quotient is zero.
  assign diff = samp_r - lo_cur;
  assign prod = MUL_W'(diff) * MUL_W'(SCALE_FACTOR);

  // one restoring step per cycle
  assign trial     = {rem_r, quo_r[QUO_BITS-1]};
  assign fits      = trial >= {1'b0, rng_r};
  assign trial_sub = trial - {1'b0, rng_r};
  assign quo_step  = {quo_r[QUO_BITS-2:0], fits};
  assign quo_clamp = (quo_step > POS_MAX) ? POS_MAX : quo_step;

  // Bound writes; every write stores the captured sample.
  always_comb begin
    wr_lo = 1'b0;
    wr_hi = 1'b0;
    if (state_r == ST_UPDATE) begin
      case (act_r)
        ACT_SCALE: begin
          // widen toward the sample; only one bound moves
          wr_lo = axis_on && (samp_r < lo_cur);
          wr_hi = axis_on && !(samp_r < lo_cur) && (samp_r > hi_cur);
        end
        ACT_RESET: begin
          wr_lo = axis_on;
          wr_hi = axis_on;
        end
        ACT_SET_LOW:  wr_lo = axis_ok;   // captures ignore active_axes
        ACT_SET_HIGH: wr_hi = axis_ok;
        default: begin
          wr_lo = 1'b0;
          wr_hi = 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = go_div ? ST_DIV : ST_DONE;
      ST_DIV:    if (cnt_r == CNT_LAST) state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_rdy   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_rdy = 1'b1;
      ST_DONE: out_load = !out_valid_r || out_ch.ready;  // output slot free or draining
      default: begin
        in_rdy   = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // control registers and bounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= ACTIVE_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        low_r[i]  <= '0;
        high_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) active_r <= cfg_ch.data;
      if (state_r == ST_SETUP) cnt_r <= '0;
      else if (state_r == ST_DIV) cnt_r <= cnt_r + CNT_W'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (wr_lo) low_r[idx]  <= samp_r;
      if (wr_hi) high_r[idx] <= samp_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r  <= act_t'(in_ch.action);
      axis_r <= in_ch.axis;
      samp_r <= in_ch.sample;
    end
    case (state_r)
      ST_SETUP: begin
        // dividend 100*d: top bits seed the remainder (below the range since
        // d <= range), low bits wait in quo_r
        rem_r <= prod[MUL_W-1:QUO_BITS];
        quo_r <= prod[QUO_BITS-1:0];
        rng_r <= hi_cur - lo_cur;
        res_scaled_r <= 1'b0;
        if ((act_r == ACT_SCALE) && !axis_on) res_pos_r <= '0;
        else res_pos_r <= POS_BITS'(samp_r);  // echo, or raw sample on empty range
      end
      ST_DIV: begin
        rem_r <= fits ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
        quo_r <= quo_step;
        if (cnt_r == CNT_LAST) begin
          res_pos_r    <= POS_BITS'(quo_clamp);
          res_scaled_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_pos_r    <= res_pos_r;
      out_scaled_r <= res_scaled_r;
    end
  end

  assign in_ch.ready     = in_rdy;
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.scaled   = out_scaled_r;

endmodule

### rtl/arn_chk.sv
// Port-level checker for the normalizer, bound to the top level.
`include "auto_ranging_axis_normalizer_core_assert.svh"

module arn_chk import arn_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [POS_BITS-1:0] out_position,
  input logic                out_scaled
);

  // one item at a time: input closes right after a transfer
  `ARN_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while busy")

  // a divided result is always clamped
  `ARN_ASSERT_IMP(a_scaled_range, clk, rst_n, out_valid && out_scaled, out_position <= POS_BITS'(POS_MAX), "scaled position above 99")

  // stalled result holds
  `ARN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_position) && $stable(out_scaled), "stalled result changed")

endmodule

bind auto_ranging_axis_normalizer_core arn_chk u_arn_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_position (out_ch.position),
  .out_scaled   (out_ch.scaled)
);

### test/tb_top.sv
// Self-checking testbench for the auto-ranging axis normalizer core.
module tb_top import arn_pkg::*; ();

  localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
  localparam int NUM_AXES      = NUM_AXES_DEF;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int IDLE_PCT      = 32;    // share of cycles each side sits idle
  localparam int SETTLE_CYCLES = 24;    // margin to let a dividing item's result come out
  localparam int DRAIN_LIMIT   = 5000;  // cycles to wait for results before giving up
  localparam int RUN_LIMIT     = 4000000;

  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic                scaled;
  } result_t;

  logic clk;
  logic rst_n;

  arn_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  arn_out_if                             out_if ();
  arn_cfg_if                             cfg_if ();

  auto_ranging_axis_normalizer_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .NUM_AXES   (NUM_AXES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  // Shadow copy of the calibration state, advanced at each accepted transfer.
  logic [SAMPLE_BITS-1:0] low_bnd  [NUM_AXES];
  logic [SAMPLE_BITS-1:0] high_bnd [NUM_AXES];
  logic [ACTIVE_BITS-1:0] active_mask;

  result_t pending_results[$];   // expected results, oldest first
  int      mismatches;
  int      items_sent;
  bit      steady_flow;          // set: neither side idles
  bit      in_driving;           // mirrors the last value put on in_if.valid

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard stop in case the handshakes lock up.
  initial begin
    #RUN_LIMIT;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // Scale a sample against the axis bounds; bounds move as the block's would.
  function automatic result_t normalize_sample(input act_t act,
                                               input logic [AXIS_BITS-1:0] ax,
                                               input logic [SAMPLE_BITS-1:0] smp);
    result_t res;
    longint  delta;
    longint  span;
    longint  quo;
    bit      in_range;
    res.position = POS_BITS'(smp);
    res.scaled   = 1'b0;
    in_range     = int'(ax) < NUM_AXES;
    case (act)
      ACT_SCALE: begin
        if (!in_range || !active_mask[ax]) begin
          res.position = '0;
        end else begin
          // only one bound moves, low takes precedence
          if (smp < low_bnd[ax]) begin
            low_bnd[ax] = smp;
          end else if (smp > high_bnd[ax]) begin
            high_bnd[ax] = smp;
          end
          if (high_bnd[ax] != low_bnd[ax]) begin
            // signed math so inverted bounds truncate toward zero before the clamp
            delta = longint'(smp) - longint'(low_bnd[ax]);
            span  = longint'(high_bnd[ax]) - longint'(low_bnd[ax]);
            quo   = (delta * SCALE_FACTOR) / span;
            if (quo < 0) quo = 0;
            if (quo > longint'(POS_MAX)) quo = longint'(POS_MAX);
            res.position = POS_BITS'(quo);
            res.scaled   = 1'b1;
          end
        end
      end
      ACT_RESET: begin
        if (in_range && active_mask[ax]) begin
          low_bnd[ax]  = smp;
          high_bnd[ax] = smp;
        end
      end
      ACT_SET_LOW: begin
        if (in_range) low_bnd[ax] = smp;
      end
      default: begin
        if (in_range) high_bnd[ax] = smp;
      end
    endcase
    return res;
  endfunction

  // One input transfer; the expectation is queued at the accepting edge.
  task automatic send_sample(input act_t act, input logic [AXIS_BITS-1:0] ax,
                             input logic [SAMPLE_BITS-1:0] smp);
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      if (in_driving) begin
        in_if.valid <= 1'b0;
        in_driving = 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.axis   <= ax;
    in_if.sample <= smp;
    in_driving = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(normalize_sample(act, ax, smp));
    items_sent++;
  endtask

  task automatic hold_input();
    if (in_driving) begin
      in_if.valid <= 1'b0;
      in_driving = 1'b0;
    end
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Register writes only go in once the block has gone quiet.
  task automatic write_active(input logic [ACTIVE_BITS-1:0] mask);
    hold_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= mask;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    active_mask = mask;
  endtask

  // Sample near one of the axis bounds, clipped to the field range.
  function automatic logic [SAMPLE_BITS-1:0] near_bound(input logic [AXIS_BITS-1:0] ax,
                                                       input int spread);
    int v;
    v = $urandom_range(0, 1) ? int'(low_bnd[ax]) : int'(high_bnd[ax]);
    v = v + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_BITS'(v);
  endfunction

  task automatic send_random_item();
    act_t                   act;
    logic [AXIS_BITS-1:0]   ax;
    logic [SAMPLE_BITS-1:0] smp;
    int                     pick;
    pick = $urandom_range(0, 99);
    if (pick < 66)      act = ACT_SCALE;
    else if (pick < 76) act = ACT_RESET;
    else if (pick < 88) act = ACT_SET_LOW;
    else                act = ACT_SET_HIGH;
    ax = AXIS_BITS'($urandom_range(0, NUM_AXES - 1));
    case ($urandom_range(0, 3))
      0, 1:    smp = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      2:       smp = near_bound(ax, 300);
      default: smp = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX)
                                          : SAMPLE_BITS'($urandom_range(0, 3));
    endcase
    send_sample(act, ax, smp);
  endtask

  // Calibration run on one axis: re-center, then a burst of scale transfers
  // around the center, with the odd manual capture thrown in.
  task automatic run_calibration_sweep();
    logic [AXIS_BITS-1:0] ax;
    int                   center;
    int                   width;
    int                   v;
    int                   n;
    ax     = AXIS_BITS'($urandom_range(0, NUM_AXES - 1));
    center = $urandom_range(0, SAMPLE_MAX);
    width  = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1000, 30000);
    n      = $urandom_range(6, 18);
    send_sample(ACT_RESET, ax, SAMPLE_BITS'(center));
    repeat (n) begin
      v = center + int'($urandom_range(0, 2 * width)) - width;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      case ($urandom_range(0, 19))
        0:       send_sample(ACT_SET_LOW, ax, SAMPLE_BITS'(v));
        1:       send_sample(ACT_SET_HIGH, ax, SAMPLE_BITS'(v));
        default: send_sample(ACT_SCALE, ax, SAMPLE_BITS'(v));
      endcase
    end
  endtask

  task automatic test_directed();
    // fresh bounds are both zero: empty range, raw sample back
    send_sample(ACT_SCALE, 2'd0, 16'h0000);
    send_sample(ACT_SCALE, 2'd0, 16'hFFFF);     // high opens to full scale, clamps to 99
    send_sample(ACT_SCALE, 2'd0, 16'h8000);
    send_sample(ACT_SCALE, 2'd0, 16'h0000);
    send_sample(ACT_RESET, 2'd1, 16'h1234);
    send_sample(ACT_SCALE, 2'd1, 16'h1234);     // range collapsed by the reset
    send_sample(ACT_SCALE, 2'd1, 16'h1000);     // low widens
    send_sample(ACT_SCALE, 2'd1, 16'h2000);     // high widens
    send_sample(ACT_SCALE, 2'd1, 16'h1800);
    // captures leave low above high
    send_sample(ACT_SET_LOW, 2'd2, 16'hAAAA);
    send_sample(ACT_SET_HIGH, 2'd2, 16'h5555);
    send_sample(ACT_SCALE, 2'd2, 16'h7000);     // low moves down, span still negative
    send_sample(ACT_SET_LOW, 2'd2, 16'hAAAA);
    send_sample(ACT_SCALE, 2'd2, 16'hC000);     // above both bounds, high moves
    send_sample(ACT_SET_HIGH, 2'd3, 16'hFFFF);
    send_sample(ACT_SCALE, 2'd3, 16'hFFFF);
    send_sample(ACT_SCALE, 2'd3, 16'h0001);
    // no sticks installed: scale gives 0, reset leaves bounds, captures still land
    write_active('0);
    send_sample(ACT_SCALE, 2'd0, 16'h4000);
    send_sample(ACT_RESET, 2'd0, 16'h4000);
    send_sample(ACT_SET_LOW, 2'd3, 16'h0100);
    send_sample(ACT_SET_HIGH, 2'd1, 16'h5555);
    write_active(4'b1001);
    send_sample(ACT_SCALE, 2'd0, 16'h4000);
    send_sample(ACT_SCALE, 2'd3, 16'h0100);
    send_sample(ACT_SCALE, 2'd1, 16'h3000);     // stick1 y now off
  endtask

  task automatic test_random_mix(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) run_calibration_sweep();
      else send_random_item();
    end
  endtask

  task automatic test_axis_masks(input int per_mask);
    logic [ACTIVE_BITS-1:0] masks[5];
    masks[0] = '0;
    masks[1] = '1;
    masks[2] = ACTIVE_BITS'($urandom_range(1, 14));
    masks[3] = ACTIVE_BITS'($urandom_range(1, 14));
    masks[4] = ACTIVE_RESET;
    foreach (masks[m]) begin
      write_active(masks[m]);
      test_random_mix(per_mask);
    end
  endtask

  // Back-to-back traffic, no idle cycles on either side.
  task automatic test_steady_stream(input int count);
    steady_flow = 1'b1;
    test_random_mix(count);
    steady_flow = 1'b0;
  endtask

  // Sender stops until the result side has caught up, then resumes.
  task automatic test_pause_and_resume(input int count);
    test_random_mix(count);
    hold_input();
    wait_drained();
    test_random_mix(count);
  endtask

  // Result side: compare every transfer with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result position=%0d scaled=%0b",
                             out_if.position, out_if.scaled));
      end else begin
        want = pending_results.pop_front();
        if (out_if.position !== want.position || out_if.scaled !== want.scaled) begin
          flag_error($sformatf("result mismatch: expected position=%0d scaled=%0b, got position=%0d scaled=%0b",
                               want.position, want.scaled, out_if.position, out_if.scaled));
        end
      end
    end
    out_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.action = ACT_SCALE;
    in_if.axis   = '0;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = ACTIVE_RESET;
    mismatches   = 0;
    items_sent   = 0;
    steady_flow  = 1'b0;
    in_driving   = 1'b0;
    active_mask  = ACTIVE_RESET;
    for (int a = 0; a < NUM_AXES; a++) begin
      low_bnd[a]  = '0;
      high_bnd[a] = '0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    write_active(ACTIVE_RESET);
    test_random_mix(600);
    test_axis_masks(100);
    test_steady_stream(400);
    test_pause_and_resume(60);

    hold_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
